>>> hw/rtl/grs_pkg.sv
`timescale 1ns / 1ps
// grs_pkg: shared types and constants for the group reverse stream core
// no dependencies

package grs_pkg;

  // one-hot sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // register index of the group size register
  localparam logic CFG_IDX_GROUP_SIZE = 1'b0;

  // reset value of the group size register
  localparam logic [3:0] GROUP_SIZE_RST = 4'd2;

endpackage

>>> hw/rtl/group_reverse_stream_core.sv
`timescale 1ns / 1ps
// group_reverse_stream_core: gathers values in a group memory and replays each group
// reversed, or a trailing partial group in order; depends on grs_pkg
// The first result of a group shows on out_valid after the sequencer enters drain, the
// registered memory read and the output register.
// Throughput: a request that completes no group is taken while the sequencer is idle; a
// request that completes a group or ends a list holds off the input while the group
// memory is read back one entry a cycle, one result a cycle when out_stall stays low.
// Reset: synchronous active-low rst_n clears the fill count, sequencer and valid bits
// and sets group_size to 2; the group memory needs no clearing pass.

module group_reverse_stream_core
  import grs_pkg::*;
#(
  parameter int MAX_GROUP = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               in_list_last,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic               out_run_last,
  output logic               out_list_end,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int AW   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW   = $clog2(MAX_GROUP + 1);
  localparam int GW   = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_GROUP);

  // group memory
  logic signed [31:0] mem [MAX_GROUP];

  state_t             state_r, state_nxt;
  logic [3:0]         group_size_r;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      num_r, num_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               rev_r, rev_nxt;
  logic               lst_r, lst_nxt;
  logic               rd_vld_r;
  logic signed [31:0] rd_data_r;
  logic               rd_run_last_r;
  logic               rd_list_end_r;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_run_last_r;
  logic               out_list_end_r;

  logic               in_acc;
  logic               cfg_wr;
  logic [CW-1:0]      fill_cnt;
  logic               flush;
  logic               move;
  logic               issue;
  logic               is_final;
  logic [CW-1:0]      rd_idx;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == CFG_IDX_GROUP_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_GROUP_SIZE) ? {28'd0, group_size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GROUP_SIZE_RST;
    end else if (cfg_wr) begin
      group_size_r <= cfg_pwdata[3:0];
    end
  end

  // request acceptance and group completion
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fill_cnt = fill_r + CW'(1);
  // a size of zero still flushes every value since the count is at least one
  assign flush    = (GW'(fill_cnt) >= GW'(group_size_r)) || (fill_cnt == MAX_CNT);

  // read-back pipeline control
  assign move     = rd_vld_r && (!out_valid_r || !out_stall);
  assign issue    = (state_r == ST_DRAIN) && (!rd_vld_r || move);
  assign is_final = (cnt_r == num_r - CW'(1));
  assign rd_idx   = rev_r ? (num_r - CW'(1) - cnt_r) : cnt_r;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    rev_nxt   = rev_r;
    lst_nxt   = lst_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (flush || in_list_last) begin
            fill_nxt  = '0;
            num_nxt   = fill_cnt;
            cnt_nxt   = '0;
            rev_nxt   = flush;
            lst_nxt   = in_list_last;
            state_nxt = ST_DRAIN;
          end else begin
            fill_nxt = fill_cnt;
          end
        end
      end
      ST_DRAIN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CW'(1);
          if (is_final) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    cnt_r <= cnt_nxt;
    rev_r <= rev_nxt;
    lst_r <= lst_nxt;
  end

  // memory write on request, registered read during drain
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[fill_r[AW-1:0]] <= in_value;
    end
    if (issue) begin
      rd_data_r <= mem[rd_idx[AW-1:0]];
    end
  end

  // read stage flags
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_run_last_r <= is_final;
      rd_list_end_r <= is_final && lst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (issue) begin
      rd_vld_r <= 1'b1;
    end else if (move) begin
      rd_vld_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_value_r    <= rd_data_r;
      out_run_last_r <= rd_run_last_r;
      out_list_end_r <= rd_list_end_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_run_last = out_run_last_r;
  assign out_list_end = out_list_end_r;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for group_reverse_stream_core, with a predictor of
// group reversal, a queue-fed request driver, a result monitor and an APB config sequence
// depends on grs_pkg and group_reverse_stream_core

module tb_top;
  import grs_pkg::*;

  localparam int GROUP_DEPTH = 8;
  localparam int RANDOM_ITEMS = 430;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] GS_ADDR = {CFG_IDX_GROUP_SIZE, 2'b00};
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               list_last;
  } list_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic               run_last;
    logic               list_end;
  } reorder_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value = '0;
  logic               in_list_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] out_value;
  logic               out_run_last;
  logic               out_list_end;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  // request queue, expected results and predictor state
  list_item_t         item_q[$];
  reorder_t           reordered_q[$];
  logic signed [31:0] grp_mem [GROUP_DEPTH];
  int unsigned        fill_cnt = 0;
  logic [3:0]         group_size_reg = GROUP_SIZE_RST;

  int  mismatches = 0;
  int  cycles = 0;
  int  in_wait = 0;
  int  out_wait = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  bit  hold_out = 1'b0;
  bit  pressure_go = 1'b0;

  group_reverse_stream_core #(.MAX_GROUP(GROUP_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_list_last (in_list_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_run_last (out_run_last),
    .out_list_end (out_list_end),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int draw_gap(bit enabled);
    if (!enabled || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // store one value and work out the results it releases, if any
  task automatic gather_value(logic signed [31:0] v, logic last);
    int unsigned g;
    int unsigned n;
    reorder_t    r;
    g = group_size_reg;
    if (g < 1) g = 1;
    if (g > GROUP_DEPTH) g = GROUP_DEPTH;
    if (fill_cnt >= GROUP_DEPTH) fill_cnt = GROUP_DEPTH - 1;
    grp_mem[fill_cnt] = v;
    fill_cnt++;
    n = fill_cnt;
    if (n >= g) begin
      // full group: replay newest first
      for (int k = 0; k < n; k++) begin
        r.value    = grp_mem[n - 1 - k];
        r.run_last = (k == n - 1);
        r.list_end = last && (k == n - 1);
        reordered_q.push_back(r);
      end
      fill_cnt = 0;
    end else if (last) begin
      // trailing partial group keeps its order
      for (int k = 0; k < n; k++) begin
        r.value    = grp_mem[k];
        r.run_last = (k == n - 1);
        r.list_end = (k == n - 1);
        reordered_q.push_back(r);
      end
      fill_cnt = 0;
    end
  endtask

  // monitor: compare results, then predict from accepted requests
  always @(posedge clk) begin : monitor
    reorder_t exp_r;
    in_took  <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reordered_q.size() == 0) begin
          report_mismatch("unexpected result", out_value, '0);
        end else begin
          exp_r = reordered_q.pop_front();
          if (out_value !== exp_r.value) report_mismatch("out_value", out_value, exp_r.value);
          if (out_run_last !== exp_r.run_last)
            report_mismatch("out_run_last", 32'(out_run_last), 32'(exp_r.run_last));
          if (out_list_end !== exp_r.list_end)
            report_mismatch("out_list_end", 32'(out_list_end), 32'(exp_r.list_end));
        end
      end
      if (in_valid && !in_stall) gather_value(in_value, in_list_last);
    end
  end

  // request driver fed from the pending queue
  always @(negedge clk) begin : tx_drive
    list_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // request still waiting, payload holds
    end else if (in_wait > 0) begin
      in_valid <= 1'b0;
      in_wait--;
    end else if (item_q.size() > 0) begin
      it = item_q.pop_front();
      in_valid     <= 1'b1;
      in_value     <= it.value;
      in_list_last <= it.list_last;
      in_wait = draw_gap(in_idle_on);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side stall, with a random wait after each accepted result
  always @(negedge clk) begin : rx_drive
    int w;
    w = out_wait;
    if (out_took) w = draw_gap(out_idle_on);
    out_stall <= hold_out || (w > 0);
    if (!hold_out && w > 0) w--;
    out_wait = w;
  end

  // long receiver hold-off so the core fills up and stalls its input
  initial begin : pressure
    do @(posedge clk); while (!pressure_go);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("group_reverse_stream_core: mismatch");
      $finish;
    end
  end

  task automatic push_item(logic signed [31:0] v, logic last);
    list_item_t it;
    it.value     = v;
    it.list_last = last;
    item_q.push_back(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (item_q.size() != 0 || in_valid || reordered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of the group size, then read back
  task automatic write_group_size(logic [3:0] gs);
    logic [31:0] rd;
    logic [31:0] upper;
    upper = $urandom;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= GS_ADDR;
    cfg_pwdata  <= {upper[31:4], gs};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    group_size_reg = gs;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[3:0] !== gs) report_mismatch("group_size read back", rd, 32'(gs));
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return -1;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  // stimulus sequence
  initial begin : stimulus
    int sent;
    int phase;
    int nlists;
    int len;
    logic [3:0] gs;
    bit close_list;
    sent = 0;
    phase = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset group size of two: extremes, leftover single, list ending on a full group
    push_item(VAL_MAX, 1'b0);
    push_item(VAL_MIN, 1'b0);
    push_item(-1, 1'b0);
    push_item(0, 1'b0);
    push_item(1, 1'b1);
    push_item(42, 1'b1);
    push_item(5, 1'b0);
    push_item(6, 1'b1);
    wait_drained();
    // group of one passes values straight through
    write_group_size(4'd1);
    push_item(7, 1'b0);
    push_item(-7, 1'b1);
    wait_drained();
    // zero behaves as one
    write_group_size(4'd0);
    push_item(32'sh55555555, 1'b0);
    push_item(32'shAAAAAAAA, 1'b1);
    wait_drained();
    // oversize saturates to the buffer depth
    write_group_size(4'd15);
    for (int i = 1; i <= 8; i++) push_item(i, i == 8);
    wait_drained();
    // lower the group size with three values already buffered
    for (int i = 0; i < 3; i++) push_item(100 + i, 1'b0);
    wait_drained();
    write_group_size(4'd2);
    push_item(103, 1'b0);
    wait_drained();

    // random phases of lists, some left open across a size change
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: gs = 4'd1;
        1: gs = 4'd8;
        2: gs = 4'd0;
        3: gs = 4'd15;
        default: begin
          if ($urandom_range(0, 9) == 0)
            gs = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
          else gs = 4'($urandom_range(1, 8));
        end
      endcase
      write_group_size(gs);
      in_idle_on  = (phase == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
      out_idle_on = ($urandom_range(0, 2) != 0);
      nlists = (phase == 1) ? 1 : $urandom_range(1, 4);
      for (int l = 0; l < nlists; l++) begin
        len = (phase == 1) ? 80 : $urandom_range(1, 20);
        close_list = (l < nlists - 1) || ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++) push_item(rand_value(), close_list && (i == len - 1));
        sent += len;
      end
      if (phase == 1) pressure_go = 1'b1;
      wait_drained();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("group_reverse_stream_core: match");
    end else begin
      $display("group_reverse_stream_core: mismatch");
    end
    $finish;
  end

endmodule
